// ----- hdl/morse_pkg.sv -----
// ----------------------------------------------------------------------------
// Morse decoder package
// Shared constants, command types and the letter/digit code table.
// ----------------------------------------------------------------------------
package morse_pkg;

   // Number of symbols kept per group; later symbols are dropped.
   localparam int KEPT_SYMBOLS = 9;
   localparam int COUNT_W      = $clog2(KEPT_SYMBOLS + 1);
   localparam int NUM_CODES    = 36;
   localparam int NUM_LETTERS  = 26;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // ASCII codes.
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_QUERY   = 8'h3F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;

   // What follows the group result of a command.
   typedef enum logic [1:0] {
      TRAIL_NONE,
      TRAIL_SPACE,
      TRAIL_NEWLINE
   } trailer_type;

   // One command: an optional closed group and an optional trailing character.
   typedef struct packed {
      logic                    has_group;
      logic                    bad;
      logic [COUNT_W-1:0]      count;
      logic [KEPT_SYMBOLS-1:0] bits;
      trailer_type             trailer;
   } cmd_type;

   // Queue status seen by the front part.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [2:0] len;
      logic [4:0] pat;
   } code_type;

   typedef struct packed {
      logic [7:0] glyph;
      logic       unknown;
   } decoded_type;

   // Code table, letters A to Z then digits 0 to 9.
   // Symbol i sits at bit i, a dash is a one.
   function automatic code_type code_entry(input int unsigned idx);
      code_type e;
      case (idx)
         0:  e = '{3'd2, 5'd2};
         1:  e = '{3'd4, 5'd1};
         2:  e = '{3'd4, 5'd5};
         3:  e = '{3'd3, 5'd1};
         4:  e = '{3'd1, 5'd0};
         5:  e = '{3'd4, 5'd4};
         6:  e = '{3'd3, 5'd3};
         7:  e = '{3'd4, 5'd0};
         8:  e = '{3'd2, 5'd0};
         9:  e = '{3'd4, 5'd14};
         10: e = '{3'd3, 5'd5};
         11: e = '{3'd4, 5'd2};
         12: e = '{3'd2, 5'd3};
         13: e = '{3'd2, 5'd1};
         14: e = '{3'd3, 5'd7};
         15: e = '{3'd4, 5'd6};
         16: e = '{3'd4, 5'd11};
         17: e = '{3'd3, 5'd2};
         18: e = '{3'd3, 5'd0};
         19: e = '{3'd1, 5'd1};
         20: e = '{3'd3, 5'd4};
         21: e = '{3'd4, 5'd8};
         22: e = '{3'd3, 5'd6};
         23: e = '{3'd4, 5'd9};
         24: e = '{3'd4, 5'd13};
         25: e = '{3'd4, 5'd3};
         26: e = '{3'd5, 5'd31};
         27: e = '{3'd5, 5'd30};
         28: e = '{3'd5, 5'd28};
         29: e = '{3'd5, 5'd24};
         30: e = '{3'd5, 5'd16};
         31: e = '{3'd5, 5'd0};
         32: e = '{3'd5, 5'd1};
         33: e = '{3'd5, 5'd3};
         34: e = '{3'd5, 5'd7};
         35: e = '{3'd5, 5'd15};
         default: e = '{3'd7, 5'd0};
      endcase
      return e;
   endfunction

   // Match a closed group against all codes in parallel.
   // Symbols above the group length are always zero, so the low five bits
   // and the length identify a code.
   function automatic decoded_type decode_group(
      input logic [KEPT_SYMBOLS-1:0] bits,
      input logic [COUNT_W-1:0]      count,
      input logic                    bad
   );
      decoded_type res;
      code_type    e;
      res.glyph   = CH_QUERY;
      res.unknown = 1'b1;
      for (int i = 0; i < NUM_CODES; i++) begin
         e = code_entry(i);
         if (!bad && count == COUNT_W'(e.len) && bits[4:0] == e.pat) begin
            res.unknown = 1'b0;
            if (i < NUM_LETTERS) begin
               res.glyph = CH_UPPER_A + 8'(i);
            end else begin
               res.glyph = CH_DIGIT_0 + 8'(i - NUM_LETTERS);
            end
         end
      end
      return res;
   endfunction

endpackage

// ----- hdl/morse_front.sv -----
// ----------------------------------------------------------------------------
// Morse decoder front part
// Accepts input bytes, gathers symbol groups and issues decode commands.
// ----------------------------------------------------------------------------
module morse_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // in_char
   input  logic                      req_tuser,   // end_of_message
   input  morse_pkg::queue_status_type queue_status,
   output logic                      push_valid,
   output morse_pkg::cmd_type        push_cmd
);

   logic [morse_pkg::KEPT_SYMBOLS-1:0] bits_ff, bits_in;
   logic [morse_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                               bad_ff, bad_in;
   logic                               accept;
   logic                               is_slash;
   logic                               is_close;

   // Input transfers wait only on room in the command queue.
   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;
   assign is_slash   = (req_tdata == morse_pkg::CH_SLASH);
   assign is_close   = is_slash || (req_tdata == morse_pkg::CH_SPACE);

   // Classify the byte and build the command for the back part.
   always_comb begin
      bits_in           = bits_ff;
      count_in          = count_ff;
      bad_in            = bad_ff;
      push_valid        = 1'b0;
      push_cmd.has_group = (count_ff != '0);
      push_cmd.bad      = bad_ff;
      push_cmd.count    = count_ff;
      push_cmd.bits     = bits_ff;
      push_cmd.trailer  = morse_pkg::TRAIL_NONE;
      if (accept) begin
         if (req_tuser || is_close) begin
            bits_in  = '0;
            count_in = '0;
            bad_in   = 1'b0;
            if (req_tuser) begin
               push_cmd.trailer = morse_pkg::TRAIL_NEWLINE;
               push_valid       = 1'b1;
            end else if (is_slash) begin
               push_cmd.trailer = morse_pkg::TRAIL_SPACE;
               push_valid       = 1'b1;
            end else begin
               push_valid = (count_ff != '0);
            end
         end else if (count_ff < morse_pkg::COUNT_W'(morse_pkg::KEPT_SYMBOLS)) begin
            if (req_tdata == morse_pkg::CH_DASH) begin
               bits_in = bits_ff | (morse_pkg::KEPT_SYMBOLS'(1) << count_ff);
            end else if (req_tdata != morse_pkg::CH_DOT) begin
               bad_in = 1'b1;
            end
            count_in = count_ff + morse_pkg::COUNT_W'(1);
         end
      end
   end

   // Group state.
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         count_ff <= '0;
         bad_ff   <= 1'b0;
      end else begin
         bits_ff  <= bits_in;
         count_ff <= count_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

// ----- hdl/morse_queue.sv -----
// ----------------------------------------------------------------------------
// Morse decoder command queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module morse_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  morse_pkg::cmd_type         push_cmd,
   input  logic                       pop,
   output logic                       head_valid,
   output morse_pkg::cmd_type         head_cmd,
   output morse_pkg::queue_status_type queue_status
);

   morse_pkg::cmd_type             slot_ff [morse_pkg::QUEUE_DEPTH];
   logic [morse_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [morse_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [morse_pkg::QCNT_W-1:0]   fill_ff, fill_in;
   logic                           do_push;
   logic                           do_pop;

   assign queue_status.full  = (fill_ff == morse_pkg::QCNT_W'(morse_pkg::QUEUE_DEPTH));
   assign queue_status.empty = (fill_ff == '0);
   assign head_valid         = !queue_status.empty;
   assign head_cmd           = slot_ff[rd_ptr_ff];
   assign do_push            = push_valid && !queue_status.full;
   assign do_pop             = pop && head_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         if (wr_ptr_ff == morse_pkg::QPTR_W'(morse_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + morse_pkg::QPTR_W'(1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == morse_pkg::QPTR_W'(morse_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + morse_pkg::QPTR_W'(1);
         end
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + morse_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - morse_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Command slots carry payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/morse_back.sv -----
// ----------------------------------------------------------------------------
// Morse decoder back part
// Decodes queued groups and sends result characters through an output register.
// ----------------------------------------------------------------------------
module morse_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  morse_pkg::cmd_type head_cmd,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // out_char
   output logic               rsp_tuser,   // unknown
   output logic               rsp_tlast    // last_in_run
);

   logic                   valid_ff, valid_in;
   logic                   group_done_ff, group_done_in;
   logic [7:0]             char_ff, char_in;
   logic                   unknown_ff, unknown_in;
   logic                   last_ff, last_in;
   logic                   load;
   morse_pkg::decoded_type decoded;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tuser  = unknown_ff;
   assign rsp_tlast  = last_ff;

   assign decoded = morse_pkg::decode_group(head_cmd.bits, head_cmd.count, head_cmd.bad);

   // The output register takes a new result when empty or being drained.
   assign load = head_valid && (!valid_ff || rsp_tready);

   // Pick the group result first, then the trailing character.
   always_comb begin
      valid_in      = valid_ff && !rsp_tready;
      group_done_in = group_done_ff;
      char_in       = char_ff;
      unknown_in    = unknown_ff;
      last_in       = last_ff;
      pop           = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head_cmd.has_group && !group_done_ff) begin
            char_in    = decoded.glyph;
            unknown_in = decoded.unknown;
            last_in    = (head_cmd.trailer == morse_pkg::TRAIL_NONE);
            if (head_cmd.trailer == morse_pkg::TRAIL_NONE) begin
               pop = 1'b1;
            end else begin
               group_done_in = 1'b1;
            end
         end else begin
            case (head_cmd.trailer)
               morse_pkg::TRAIL_SPACE:   char_in = morse_pkg::CH_SPACE;
               morse_pkg::TRAIL_NEWLINE: char_in = morse_pkg::CH_NEWLINE;
               default:                  char_in = morse_pkg::CH_QUERY;
            endcase
            unknown_in    = 1'b0;
            last_in       = 1'b1;
            pop           = 1'b1;
            group_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         group_done_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         group_done_ff <= group_done_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff    <= char_in;
      unknown_ff <= unknown_in;
      last_ff    <= last_in;
   end

endmodule

// ----- hdl/morse_text_decoder.sv -----
// A command is registered in the command queue, then its result in the output register.
// Throughput: one input byte per cycle unless the queue is full; one result per cycle
// unless stalled; a slash or end-of-message item with two results sends them in turn.
// The two-entry command queue sets how far the front part can run ahead of the back part.
// Reset clears the symbol group, the command queue and the output register.
// ----------------------------------------------------------------------------
// Morse text decoder
// Turns a stream of Morse text bytes into decoded letters, digits and spacing.
// ----------------------------------------------------------------------------
module morse_text_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tuser,   // [0] end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tuser,   // [0] unknown
   output logic       rsp_tlast    // last_in_run
);

   logic                        push_valid;
   morse_pkg::cmd_type          push_cmd;
   logic                        pop;
   logic                        head_valid;
   morse_pkg::cmd_type          head_cmd;
   morse_pkg::queue_status_type queue_status;

   morse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd)
   );

   morse_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd),
      .pop          (pop),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .queue_status (queue_status)
   );

   morse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The front part never writes a command into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      !(push_valid && queue_status.full))
      else $error("command written into a full queue");

   // An unknown group always shows as a question mark.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == morse_pkg::CH_QUERY))
      else $error("unknown result without question mark");

   // Space and newline only come as the final, known result of an item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata == morse_pkg::CH_SPACE ||
                      rsp_tdata == morse_pkg::CH_NEWLINE)) |-> (rsp_tlast && !rsp_tuser))
      else $error("spacing result not final or flagged unknown");

endmodule
